// ===== rtl/core/ieb_pkg.sv =====
// types and constants shared by the serial eeprom byte master
// no dependencies

package ieb_pkg;

	localparam int unsigned HalfW = 10;
	localparam int unsigned WaitW = 20;
	localparam int unsigned SelW  = 3;

	// bus sequencer phase codes; the byte shift slots occupy
	// PH_TXB .. PH_TXB+15, four sub-phases for each of four bytes
	localparam logic [4:0] PH_IDLE    = 5'd0;
	localparam logic [4:0] PH_ST1     = 5'd1;
	localparam logic [4:0] PH_ST2     = 5'd2;
	localparam logic [4:0] PH_TXB     = 5'd3;
	localparam logic [4:0] PH_RS_LO   = 5'd19;
	localparam logic [4:0] PH_RS_HI   = 5'd20;
	localparam logic [4:0] PH_RS_FALL = 5'd21;
	localparam logic [4:0] PH_RX_LO   = 5'd22;
	localparam logic [4:0] PH_RX_HI   = 5'd23;
	localparam logic [4:0] PH_NK_LO   = 5'd24;
	localparam logic [4:0] PH_NK_HI   = 5'd25;
	localparam logic [4:0] PH_SP_LO   = 5'd26;
	localparam logic [4:0] PH_SP_HI   = 5'd27;
	localparam logic [4:0] PH_SP_END  = 5'd28;
	localparam logic [4:0] PH_WWAIT   = 5'd29;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] REG_HALF = 2'd0;
	localparam logic [1:0] REG_WAIT = 2'd1;
	localparam logic [1:0] REG_SEL  = 2'd2;

	localparam logic [7:0] CTL_WRITE = 8'hA0;
	localparam logic [7:0] CTL_READ  = 8'hA1;
	localparam logic [7:0] MSB_MASK  = 8'h80;

	localparam logic [HalfW-1:0] HALF_RESET = 10'd4;
	localparam logic [WaitW-1:0] WAIT_RESET = 20'd500000;
	localparam logic [SelW-1:0]  SEL_RESET  = 3'd0;

	typedef struct packed {
		logic [HalfW-1:0] half_period_ticks;
		logic [WaitW-1:0] write_wait_ticks;
		logic [SelW-1:0]  device_select;
	} cfg_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
	} res_t;

endpackage

// ===== rtl/core/ieb_cfg_regs.sv =====
// configuration register file of the eeprom byte master
// depends on ieb_pkg

module ieb_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [ieb_pkg::WaitW-1:0]  cfg_wdata,
	output ieb_pkg::cfg_t              cfg
);
	import ieb_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= HALF_RESET;
			cfg_q.write_wait_ticks  <= WAIT_RESET;
			cfg_q.device_select     <= SEL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HALF: cfg_q.half_period_ticks <= cfg_wdata[HalfW-1:0];
				REG_WAIT: cfg_q.write_wait_ticks  <= cfg_wdata;
				REG_SEL:  cfg_q.device_select     <= cfg_wdata[SelW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/ieb_seq.sv =====
// bus sequencer: advances one tick per accepted beat and gives the
// line levels and status for the state after that tick; depends on ieb_pkg

module ieb_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [1:0]    cmd,
	input  logic [7:0]    mem_address,
	input  logic [7:0]    write_data,
	input  logic          sda_in,
	input  ieb_pkg::cfg_t cfg,
	output ieb_pkg::res_t res
);
	import ieb_pkg::*;

	logic [4:0]       phase_q, phase_d;
	logic [2:0]       bit_index_q, bit_index_d;
	logic [7:0]       shift_q, shift_d;
	logic [7:0]       rx_q, rx_d;
	logic [HalfW-1:0] div_q, div_d;
	logic [WaitW-1:0] wait_q, wait_d;
	logic             rd_q, rd_d;
	logic [7:0]       addr_q, addr_d;
	logic [7:0]       data_q, data_d;

	logic [HalfW-1:0] half;
	logic [HalfW:0]   div_inc;
	logic [7:0]       ctl_wr, ctl_rd;
	logic             in_tx, done;
	logic [4:0]       rel;
	logic [WaitW-1:0] wait_dec;

	assign half    = (cfg.half_period_ticks == '0) ? HalfW'(1) : cfg.half_period_ticks;
	assign div_inc = {1'b0, div_q} + (HalfW+1)'(1);
	assign ctl_wr  = CTL_WRITE | {4'd0, cfg.device_select, 1'b0};
	assign ctl_rd  = CTL_READ | {4'd0, cfg.device_select, 1'b0};
	assign in_tx   = (phase_q >= PH_TXB) && (phase_q < PH_RS_LO);
	assign rel     = phase_q - PH_TXB;
	assign wait_dec = (wait_q != '0) ? wait_q - WaitW'(1) : wait_q;

	always_comb begin
		phase_d     = phase_q;
		bit_index_d = bit_index_q;
		shift_d     = shift_q;
		rx_d        = rx_q;
		div_d       = div_q;
		wait_d      = wait_q;
		rd_d        = rd_q;
		addr_d      = addr_q;
		data_d      = data_q;
		done        = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (cmd == CMD_WRITE || cmd == CMD_READ) begin
				rd_d    = (cmd == CMD_READ);
				addr_d  = mem_address;
				data_d  = write_data;
				div_d   = '0;
				phase_d = PH_ST1;
			end
		end else if (phase_q == PH_WWAIT) begin
			wait_d = wait_dec;
			if (wait_dec == '0) begin
				phase_d = PH_IDLE;
				done    = 1'b1;
			end
		end else if (phase_q > PH_WWAIT) begin
			phase_d = PH_IDLE;
		end else if (div_inc < {1'b0, half}) begin
			div_d = div_inc[HalfW-1:0];
		end else if (in_tx && rel[1:0] == 2'd3 && sda_in) begin
			// ack slot: hold scl high until the slave pulls sda low
			div_d = half;
		end else begin
			div_d = '0;
			if (in_tx) begin
				case (rel[1:0])
					2'd1: begin
						if (bit_index_q == 3'd7) begin
							phase_d = phase_q + 5'd1;
						end else begin
							bit_index_d = bit_index_q + 3'd1;
							shift_d     = {shift_q[6:0], 1'b0};
							phase_d     = phase_q - 5'd1;
						end
					end
					2'd3: begin
						bit_index_d = '0;
						case (rel[3:2])
							2'd0: begin
								shift_d = addr_q;
								phase_d = PH_TXB + 5'd4;
							end
							2'd1: begin
								if (rd_q) begin
									phase_d = PH_RS_LO;
								end else begin
									shift_d = data_q;
									phase_d = PH_TXB + 5'd8;
								end
							end
							2'd2: phase_d = PH_SP_LO;
							default: begin
								shift_d = '0;
								phase_d = PH_RX_LO;
							end
						endcase
					end
					default: phase_d = phase_q + 5'd1;
				endcase
			end else begin
				unique case (phase_q)
					PH_ST1: phase_d = PH_ST2;
					PH_ST2: begin
						shift_d     = ctl_wr;
						bit_index_d = '0;
						phase_d     = PH_TXB;
					end
					PH_RS_LO: phase_d = PH_RS_HI;
					PH_RS_HI: phase_d = PH_RS_FALL;
					PH_RS_FALL: begin
						shift_d     = ctl_rd;
						bit_index_d = '0;
						phase_d     = PH_TXB + 5'd12;
					end
					PH_RX_LO: phase_d = PH_RX_HI;
					PH_RX_HI: begin
						shift_d = {shift_q[6:0], sda_in};
						if (bit_index_q == 3'd7) begin
							rx_d    = {shift_q[6:0], sda_in};
							phase_d = PH_NK_LO;
						end else begin
							bit_index_d = bit_index_q + 3'd1;
							phase_d     = PH_RX_LO;
						end
					end
					PH_NK_LO: phase_d = PH_NK_HI;
					PH_NK_HI: phase_d = PH_SP_LO;
					PH_SP_LO: phase_d = PH_SP_HI;
					PH_SP_HI: phase_d = PH_SP_END;
					PH_SP_END: begin
						if (!rd_q && cfg.write_wait_ticks != '0) begin
							wait_d  = cfg.write_wait_ticks;
							phase_d = PH_WWAIT;
						end else begin
							phase_d = PH_IDLE;
							done    = 1'b1;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// line levels for the state after this tick
	logic [4:0] nrel;
	logic       ntx;

	assign ntx  = (phase_d >= PH_TXB) && (phase_d < PH_RS_LO);
	assign nrel = phase_d - PH_TXB;

	always_comb begin
		res.busy_res  = (phase_d != PH_IDLE);
		res.done_res  = done;
		res.read_byte = rx_d;
		if (ntx) begin
			res.scl_out     = nrel[0];
			res.sda_release = nrel[1] ? 1'b1 : ((shift_d & MSB_MASK) != 8'd0);
		end else begin
			case (phase_d)
				PH_ST2, PH_RS_FALL, PH_SP_HI: begin
					res.scl_out     = 1'b1;
					res.sda_release = 1'b0;
				end
				PH_RS_LO, PH_RX_LO, PH_NK_LO: begin
					res.scl_out     = 1'b0;
					res.sda_release = 1'b1;
				end
				PH_SP_LO: begin
					res.scl_out     = 1'b0;
					res.sda_release = 1'b0;
				end
				default: begin
					res.scl_out     = 1'b1;
					res.sda_release = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_index_q <= '0;
			shift_q     <= '0;
			rx_q        <= '0;
			div_q       <= '0;
			wait_q      <= '0;
			rd_q        <= 1'b0;
			addr_q      <= '0;
			data_q      <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			bit_index_q <= bit_index_d;
			shift_q     <= shift_d;
			rx_q        <= rx_d;
			div_q       <= div_d;
			wait_q      <= wait_d;
			rd_q        <= rd_d;
			addr_q      <= addr_d;
			data_q      <= data_d;
		end
	end

endmodule

// ===== rtl/core/i2c_eeprom_byte_master.sv =====
// top level of the serial eeprom byte master: stream ports, config
// registers and the result register; depends on ieb_pkg, ieb_cfg_regs, ieb_seq
//
// Usage: every input beat is one tick of the bus sequencer. s_tuser carries
// the command (tick only, byte write, random read); a command is taken only
// while the sequencer is idle and is otherwise treated as a plain tick.
// s_tdata carries the word address, the write byte and the sampled sda level.
// Each input beat yields exactly one output beat holding scl, the sda
// release level, busy, a done pulse and the last byte read, for the state
// after that tick.
// Latency: the result of a beat is presented on m_tdata the cycle after it
// is accepted. Throughput: one beat per cycle while m_tready stays high, set by the
// single result register; the sequencer step itself is combinational logic.
// When the receiver stalls, the result register holds and s_tready drops
// until it is taken, so no tick is lost or applied twice.
// Reset (arst_n low) returns the sequencer to idle, empties the result
// register and loads the register defaults: half period 4 ticks, write
// wait 500000 ticks, device select 0. Registers are written through cfg_we/cfg_index/
// cfg_wdata; the user writes them only while the block is idle, the block does not enforce it.

module i2c_eeprom_byte_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // mem_address, write_data, sda_in, zero pad
	input  logic [1:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // scl_out, sda_release, busy_res, done_res,
	                               // read_byte, zero pad
);
	import ieb_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t res_q;
	logic out_valid_q;
	logic step;

	assign s_tready = !out_valid_q || m_tready;
	assign step     = s_tvalid && s_tready;

	ieb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ieb_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.cmd         (s_tuser),
		.mem_address (s_tdata[7:0]),
		.write_data  (s_tdata[15:8]),
		.sda_in      (s_tdata[16]),
		.cfg         (cfg),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded with each accepted beat
	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, res_q.read_byte, res_q.done_res, res_q.busy_res,
		res_q.sda_release, res_q.scl_out};

endmodule
